// ===== hw/rtl/rmft_pkg.sv =====
// ----------------------------------------------------------------------------
// rmft_pkg
// Shared types and constants of the range match flow table.
// ----------------------------------------------------------------------------
package rmft_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int IP_W    = 10;
   localparam int PORT_W  = 2;
   localparam int KIND_W  = 2;
   localparam int HIT_W   = 32;
   localparam int RIDX_W  = 4;

   localparam logic [IP_W-1:0]   IP_RESET_HIGH = 10'd1000;
   localparam logic [PORT_W-1:0] LOCAL_PORT    = 2'd3;
   localparam logic [PORT_W-1:0] NO_PORT       = 2'd0;
   localparam logic [HIT_W-1:0]  HITS_NEW      = 32'd1;

   localparam logic ACT_ADMIT = 1'b0;
   localparam logic ACT_ADD   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_DROP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FWD  = 2'd1;

   localparam logic CSR_LOCAL_LOW  = 1'b0;
   localparam logic CSR_LOCAL_HIGH = 1'b1;

   typedef enum logic [2:0] {
      ST_LOCAL   = 3'd0,
      ST_FORWARD = 3'd1,
      ST_DROP    = 3'd2,
      ST_MISS    = 3'd3,
      ST_ADDED   = 3'd4,
      ST_INVALID = 3'd5,
      ST_FULL    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SEARCH,
      CS_HIT,
      CS_ADD,
      CS_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic              action;
      logic [IP_W-1:0]   src_ip;
      logic [IP_W-1:0]   dest_ip;
      logic [KIND_W-1:0] rule_kind;
      logic [IP_W-1:0]   rule_low;
      logic [IP_W-1:0]   rule_high;
      logic [PORT_W-1:0] rule_port;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PORT_W-1:0] out_port;
      logic [IP_W-1:0]   out_src_ip;
      logic [IP_W-1:0]   out_dest_ip;
      logic [RIDX_W-1:0] rule_index;
      logic [HIT_W-1:0]  hit_count;
   } rsp_type;

   typedef struct packed {
      logic [IP_W-1:0]   low;
      logic [IP_W-1:0]   high;
      logic              forwards;
      logic [PORT_W-1:0] port;
   } rule_type;

   typedef struct packed {
      logic             rule_we;
      logic             hits_we;
      rule_type         rule;
      logic [HIT_W-1:0] hits;
   } mem_wr_type;

endpackage

// ===== hw/rtl/rmft_store.sv =====
// ----------------------------------------------------------------------------
// rmft_store
// Rule and hit count memories, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module rmft_store #(
   parameter int TABLE_ENTRIES = rmft_pkg::TABLE_ENTRIES_DEF,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                       clock,
   input  logic [IDX_W-1:0]           rd_addr,
   input  logic [IDX_W-1:0]           wr_addr,
   input  rmft_pkg::mem_wr_type       wr,
   output rmft_pkg::rule_type         rd_rule,
   output logic [rmft_pkg::HIT_W-1:0] rd_hits
);
   import rmft_pkg::*;

   rule_type         rule_mem_ff [TABLE_ENTRIES];
   logic [HIT_W-1:0] hits_mem_ff [TABLE_ENTRIES];
   rule_type         rd_rule_ff;
   logic [HIT_W-1:0] rd_hits_ff;

   always_ff @(posedge clock) begin
      if (wr.rule_we) begin
         rule_mem_ff[wr_addr] <= wr.rule;
      end
      if (wr.hits_we) begin
         hits_mem_ff[wr_addr] <= wr.hits;
      end
      rd_rule_ff <= rule_mem_ff[rd_addr];
      rd_hits_ff <= hits_mem_ff[rd_addr];
   end

   assign rd_rule = rd_rule_ff;
   assign rd_hits = rd_hits_ff;

endmodule

// ===== hw/rtl/rmft_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmft_ctrl
// Sequencer with the shared range compare and hit count unit, one table
// entry per cycle, plus the result register.
// ----------------------------------------------------------------------------
module rmft_ctrl #(
   parameter int TABLE_ENTRIES = rmft_pkg::TABLE_ENTRIES_DEF,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES),
   parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rmft_pkg::req_type          req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rmft_pkg::rsp_type          rsp_item,
   input  logic [rmft_pkg::IP_W-1:0]  local_low,
   input  logic [rmft_pkg::IP_W-1:0]  local_high,
   output logic [IDX_W-1:0]           rd_addr,
   output logic [IDX_W-1:0]           wr_addr,
   output rmft_pkg::mem_wr_type       wr,
   input  rmft_pkg::rule_type         rd_rule,
   input  logic [rmft_pkg::HIT_W-1:0] rd_hits
);
   import rmft_pkg::*;

   localparam logic [CNT_W-1:0] ENTRIES_MAX = CNT_W'(TABLE_ENTRIES);

   ctrl_state_type    state_ff, state_in;
   req_type           item_ff, item_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [HIT_W-1:0]  hit0_ff, hit0_in;
   logic              m_fwd_ff, m_fwd_in;
   logic [PORT_W-1:0] m_port_ff, m_port_in;
   logic [HIT_W-1:0]  m_hits_ff, m_hits_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              first_entry;
   logic [IP_W-1:0]   cur_lo;
   logic [IP_W-1:0]   cur_hi;
   logic              cur_fwd;
   logic [PORT_W-1:0] cur_port;
   logic [HIT_W-1:0]  cur_hits;
   logic              in_range;
   logic              at_end;
   logic [HIT_W-1:0]  hits_inc;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // shared compare unit: entry 0 is the built-in local rule
   assign first_entry = (idx_ff == '0);
   assign cur_lo      = first_entry ? local_low  : rd_rule.low;
   assign cur_hi      = first_entry ? local_high : rd_rule.high;
   assign cur_fwd     = first_entry ? 1'b1       : rd_rule.forwards;
   assign cur_port    = first_entry ? LOCAL_PORT : rd_rule.port;
   assign cur_hits    = first_entry ? hit0_ff    : rd_hits;
   assign in_range    = (item_ff.dest_ip >= cur_lo) && (item_ff.dest_ip <= cur_hi);
   assign at_end      = (idx_ff >= used_ff);
   assign hits_inc    = (m_hits_ff == '1) ? m_hits_ff : m_hits_ff + HITS_NEW;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_accept) begin
               state_in = (req_item.action == ACT_ADD) ? CS_ADD : CS_SEARCH;
            end
         end
         CS_SEARCH: begin
            if (at_end) begin
               state_in = CS_FINISH;
            end else if (in_range) begin
               state_in = CS_HIT;
            end
         end
         CS_HIT:    state_in = CS_FINISH;
         CS_ADD:    state_in = CS_FINISH;
         CS_FINISH: begin
            if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         default:   state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      item_in      = item_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      hit0_in      = hit0_ff;
      m_fwd_in     = m_fwd_ff;
      m_port_in    = m_port_ff;
      m_hits_in    = m_hits_ff;
      res_in       = res_ff;
      wr           = '0;
      wr_addr      = used_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      res_in.out_src_ip = item_ff.src_ip;

      case (state_ff)
         CS_IDLE: begin
            req_ready = !reset;
            idx_in    = '0;
            if (req_valid) begin
               item_in = req_item;
            end
         end
         CS_SEARCH: begin
            res_in.out_dest_ip = item_ff.dest_ip;
            if (at_end) begin
               res_in.status     = ST_MISS;
               res_in.out_port   = NO_PORT;
               res_in.rule_index = '0;
               res_in.hit_count  = '0;
            end else if (in_range) begin
               m_fwd_in  = cur_fwd;
               m_port_in = cur_port;
               m_hits_in = cur_hits;
            end else begin
               idx_in = CNT_W'(idx_ff + 1'b1);
            end
         end
         CS_HIT: begin
            wr_addr = idx_ff[IDX_W-1:0];
            if (first_entry) begin
               hit0_in = hits_inc;
            end else begin
               wr.hits_we = 1'b1;
               wr.hits    = hits_inc;
            end
            res_in.rule_index = RIDX_W'(idx_ff);
            res_in.hit_count  = hits_inc;
            if (!m_fwd_ff) begin
               res_in.status   = ST_DROP;
               res_in.out_port = NO_PORT;
            end else if (m_port_ff == LOCAL_PORT) begin
               res_in.status   = ST_LOCAL;
               res_in.out_port = LOCAL_PORT;
            end else begin
               res_in.status   = ST_FORWARD;
               res_in.out_port = m_port_ff;
            end
         end
         CS_ADD: begin
            res_in.out_dest_ip = item_ff.rule_low;
            res_in.out_port    = NO_PORT;
            res_in.rule_index  = '0;
            res_in.hit_count   = '0;
            if (item_ff.rule_kind > KIND_FWD) begin
               res_in.status = ST_INVALID;
            end else if (used_ff >= ENTRIES_MAX) begin
               res_in.status = ST_FULL;
            end else begin
               wr.rule_we        = 1'b1;
               wr.hits_we        = 1'b1;
               wr.rule.low       = item_ff.rule_low;
               wr.rule.high      = item_ff.rule_high;
               wr.rule.forwards  = (item_ff.rule_kind == KIND_FWD);
               wr.rule.port      = (item_ff.rule_kind == KIND_FWD) ? item_ff.rule_port : NO_PORT;
               wr.hits           = HITS_NEW;
               used_in           = CNT_W'(used_ff + 1'b1);
               res_in.status     = ST_ADDED;
               res_in.out_port   = wr.rule.port;
               res_in.rule_index = RIDX_W'(used_ff);
               res_in.hit_count  = HITS_NEW;
            end
         end
         CS_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = idx_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         used_ff      <= CNT_W'(1);
         hit0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         hit0_ff      <= hit0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      m_fwd_ff    <= m_fwd_in;
      m_port_ff   <= m_port_in;
      m_hits_ff   <= m_hits_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_data_ff;

endmodule

// ===== hw/rtl/range_match_flow_table_core.sv =====
// ----------------------------------------------------------------------------
// range_match_flow_table_core
// First-match destination range flow table with a built-in local rule.
//
//   channel  dir  data                                    handshake
//   req_     in   tuser: action; tdata: see port          tvalid/tready
//   rsp_     out  tuser: status; tdata: see port          tvalid/tready
//   csr_     in   index 0 local low, 1 local high         csr_we
//
// The single range compare unit steps one entry per cycle through the rule
// memory read port. Synchronous reset restores the local bounds and leaves
// only the local rule; no memory sweep is needed. A stalled rsp_ holds its
// word; req_ is taken again while that word waits.
// ----------------------------------------------------------------------------
module range_match_flow_table_core #(
   parameter int TABLE_ENTRIES = rmft_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [0:0]                req_tuser,  // action
   // src_ip, dest_ip, rule_kind, rule_low, rule_high, rule_port, pad
   input  logic [47:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2:0]                rsp_tuser,  // status
   // out_port, out_src_ip, out_dest_ip, rule_index, hit_count, pad
   output logic [63:0]               rsp_tdata,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [rmft_pkg::IP_W-1:0] csr_wdata
);
   import rmft_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [IP_W-1:0] local_low_ff, local_low_in;
   logic [IP_W-1:0] local_high_ff, local_high_in;

   req_type          req_item;
   rsp_type          rsp_item;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   mem_wr_type       wr;
   rule_type         rd_rule;
   logic [HIT_W-1:0] rd_hits;

   always_comb begin
      local_low_in  = local_low_ff;
      local_high_in = local_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOCAL_LOW:  local_low_in  = csr_wdata;
            CSR_LOCAL_HIGH: local_high_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_low_ff  <= '0;
         local_high_ff <= IP_RESET_HIGH;
      end else begin
         local_low_ff  <= local_low_in;
         local_high_ff <= local_high_in;
      end
   end

   assign req_item.action    = req_tuser[0];
   assign req_item.src_ip    = req_tdata[9:0];
   assign req_item.dest_ip   = req_tdata[19:10];
   assign req_item.rule_kind = req_tdata[21:20];
   assign req_item.rule_low  = req_tdata[31:22];
   assign req_item.rule_high = req_tdata[41:32];
   assign req_item.rule_port = req_tdata[43:42];

   rmft_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item),
      .local_low  (local_low_ff),
      .local_high (local_high_ff),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr         (wr),
      .rd_rule    (rd_rule),
      .rd_hits    (rd_hits)
   );

   rmft_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr      (wr),
      .rd_rule (rd_rule),
      .rd_hits (rd_hits)
   );

   assign rsp_tuser = rsp_item.status;
   assign rsp_tdata = {6'd0, rsp_item.hit_count, rsp_item.rule_index,
                       rsp_item.out_dest_ip, rsp_item.out_src_ip, rsp_item.out_port};

endmodule

// ===== tb/range_match_flow_table_core_test.sv =====
// ----------------------------------------------------------------------------
// range_match_flow_table_core_test
// Self-checking bench for the first-match range flow table. A short scripted
// part covers reset hits, misses, invalid kinds, drop and forward rules,
// empty ranges and the forward-to-local case. Random traffic follows over
// several local-rule bound settings. Each response word is compared against the
// scripted expected word or a shadow copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module range_match_flow_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rmft_pkg::*;

   localparam int NUM_ENTRIES  = TABLE_ENTRIES_DEF;
   localparam int RANDOM_WORDS = 1250;
   localparam int NUM_PHASES   = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = NUM_ENTRIES + 8;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } script_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [0:0]        req_tuser  = '0;
   logic [47:0]       req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [2:0]        rsp_tuser;
   logic [63:0]       rsp_tdata;
   logic              csr_we     = 1'b0;
   logic              csr_index  = CSR_LOCAL_LOW;
   logic [IP_W-1:0]   csr_wdata  = '0;

   script_row_type script[$];
   rsp_type        route_q[$];
   int             errors = 0;
   int             cycles = 0;
   int             burst_left = 0;

   // shadow of the rule table
   logic [IP_W-1:0]   loc_lo = '0;
   logic [IP_W-1:0]   loc_hi = IP_RESET_HIGH;
   logic [IP_W-1:0]   sh_lo   [NUM_ENTRIES];
   logic [IP_W-1:0]   sh_hi   [NUM_ENTRIES];
   logic              sh_fwd  [NUM_ENTRIES];
   logic [PORT_W-1:0] sh_port [NUM_ENTRIES];
   logic [HIT_W-1:0]  sh_hits [NUM_ENTRIES];
   int                sh_used = 1;

   int          ready_span = 0;
   int          ready_mode = 0;
   logic [31:0] ready_pat  = '1;

   range_match_flow_table_core #(
      .TABLE_ENTRIES(NUM_ENTRIES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      sh_fwd[0]  = 1'b1;
      sh_port[0] = LOCAL_PORT;
      sh_hits[0] = '0;
      sh_lo[0]   = '0;
      sh_hi[0]   = '0;
   end

   function automatic rsp_type predict_route(req_type r);
      rsp_type         res;
      logic [IP_W-1:0] lo;
      logic [IP_W-1:0] hi;
      bit              found;
      res = '0;
      res.out_src_ip = r.src_ip;
      found = 1'b0;
      if (r.action == ACT_ADMIT) begin
         res.status = ST_MISS;
         res.out_dest_ip = r.dest_ip;
         for (int i = 0; i < sh_used; i++) begin
            lo = (i == 0) ? loc_lo : sh_lo[i];
            hi = (i == 0) ? loc_hi : sh_hi[i];
            if (!found && r.dest_ip >= lo && r.dest_ip <= hi) begin
               found = 1'b1;
               if (sh_hits[i] != '1) sh_hits[i] = sh_hits[i] + 1;
               res.rule_index = RIDX_W'(i);
               res.hit_count = sh_hits[i];
               if (!sh_fwd[i]) begin
                  res.status = ST_DROP;
               end else if (sh_port[i] == LOCAL_PORT) begin
                  res.status = ST_LOCAL;
                  res.out_port = LOCAL_PORT;
               end else begin
                  res.status = ST_FORWARD;
                  res.out_port = sh_port[i];
               end
            end
         end
      end else begin
         res.out_dest_ip = r.rule_low;
         if (r.rule_kind != KIND_DROP && r.rule_kind != KIND_FWD) begin
            res.status = ST_INVALID;
         end else if (sh_used >= NUM_ENTRIES) begin
            res.status = ST_FULL;
         end else begin
            sh_lo[sh_used]   = r.rule_low;
            sh_hi[sh_used]   = r.rule_high;
            sh_fwd[sh_used]  = (r.rule_kind == KIND_FWD);
            sh_port[sh_used] = (r.rule_kind == KIND_FWD) ? r.rule_port : NO_PORT;
            sh_hits[sh_used] = HITS_NEW;
            res.status     = ST_ADDED;
            res.out_port   = sh_port[sh_used];
            res.rule_index = RIDX_W'(sh_used);
            res.hit_count  = HITS_NEW;
            sh_used++;
         end
      end
      return res;
   endfunction

   function automatic req_type pick_word();
      req_type         w;
      int              k;
      int              t;
      logic [IP_W-1:0] base;
      w.action    = ($urandom_range(0, 99) < 8) ? ACT_ADD : ACT_ADMIT;
      w.src_ip    = IP_W'($urandom_range(0, 1023));
      w.rule_kind = ($urandom_range(0, 9) < 7) ? KIND_W'($urandom_range(0, 1))
                                               : KIND_W'($urandom_range(2, 3));
      w.rule_low  = IP_W'($urandom_range(0, 1023));
      t = int'(w.rule_low) + int'($urandom_range(0, 120));
      if ($urandom_range(0, 4) != 0) w.rule_high = (t > 1023) ? 10'd1023 : IP_W'(t);
      else w.rule_high = IP_W'($urandom_range(0, 1023));
      w.rule_port = PORT_W'($urandom_range(0, 3));
      if (w.action == ACT_ADMIT && $urandom_range(0, 9) < 4) begin
         k = $urandom_range(0, sh_used - 1);
         if (k == 0) base = $urandom_range(0, 1) ? loc_lo : loc_hi;
         else base = $urandom_range(0, 1) ? sh_lo[k] : sh_hi[k];
         t = int'(base) + int'($urandom_range(0, 2)) - 1;
         w.dest_ip = IP_W'(t);
      end else begin
         w.dest_ip = IP_W'($urandom_range(0, 1023));
      end
      return w;
   endfunction

   task automatic add_row(input logic act, input int src, input int dst, input int kind,
                          input int lo, input int hi, input int port, input bit typed,
                          input status_type st, input int op, input int idx,
                          input int hits);
      script_row_type row;
      row.req.action    = act;
      row.req.src_ip    = IP_W'(src);
      row.req.dest_ip   = IP_W'(dst);
      row.req.rule_kind = KIND_W'(kind);
      row.req.rule_low  = IP_W'(lo);
      row.req.rule_high = IP_W'(hi);
      row.req.rule_port = PORT_W'(port);
      row.typed = typed;
      row.rsp.status      = st;
      row.rsp.out_port    = PORT_W'(op);
      row.rsp.out_src_ip  = IP_W'(src);
      row.rsp.out_dest_ip = (act == ACT_ADD) ? IP_W'(lo) : IP_W'(dst);
      row.rsp.rule_index  = RIDX_W'(idx);
      row.rsp.hit_count   = HIT_W'(hits);
      script.insert(script.size(), row);
   endtask

   task automatic send_item(input req_type r, input bit typed, input rsp_type given);
      rsp_type p;
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {4'b0, r.rule_port, r.rule_high, r.rule_low, r.rule_kind,
                     r.dest_ip, r.src_ip};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_route(r);
      route_q.insert(route_q.size(), typed ? given : p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(0, 20);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (route_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_local_bounds(input logic [IP_W-1:0] lo, input logic [IP_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOCAL_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_LOCAL_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      loc_lo = lo;
      loc_hi = hi;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_pat  = $urandom;
         ready_span = $urandom_range(8, 64);
      end
      ready_span--;
      ready_pat = {ready_pat[30:0], ready_pat[31]};
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ready_pat[0];
         end
      endcase
   end

   always @(posedge clock) begin : rsp_check
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status      = status_type'(rsp_tuser);
         seen.out_port    = rsp_tdata[1:0];
         seen.out_src_ip  = rsp_tdata[11:2];
         seen.out_dest_ip = rsp_tdata[21:12];
         seen.rule_index  = rsp_tdata[25:22];
         seen.hit_count   = rsp_tdata[57:26];
         if (route_q.size() == 0) begin
            $display("%0t unexpected word expected none actual status %0d",
                     $time, seen.status);
            errors++;
         end else begin
            want = route_q.pop_front();
            check_field("status", want.status, seen.status);
            check_field("out_port", want.out_port, seen.out_port);
            check_field("out_src_ip", want.out_src_ip, seen.out_src_ip);
            check_field("out_dest_ip", want.out_dest_ip, seen.out_dest_ip);
            check_field("rule_index", want.rule_index, seen.rule_index);
            check_field("hit_count", want.hit_count, seen.hit_count);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d words outstanding", $time, route_q.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [IP_W-1:0] lo;
      logic [IP_W-1:0] hi;
      rsp_type         none;
      none = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_local_bounds('0, IP_RESET_HIGH);

      add_row(ACT_ADMIT,    0,  500, 0,    0,    0, 0, 1, ST_LOCAL,   3, 0, 1);
      add_row(ACT_ADMIT, 1023,    0, 3, 1023, 1023, 3, 1, ST_LOCAL,   3, 0, 2);
      add_row(ACT_ADMIT,  555, 1000, 1,    7,    9, 1, 1, ST_LOCAL,   3, 0, 3);
      add_row(ACT_ADMIT,    1, 1001, 0,    0,    0, 0, 1, ST_MISS,    0, 0, 0);
      add_row(ACT_ADMIT,  512, 1023, 2,    0, 1023, 2, 1, ST_MISS,    0, 0, 0);
      add_row(ACT_ADD,     33,    0, 2, 1023,    0, 1, 1, ST_INVALID, 0, 0, 0);
      add_row(ACT_ADD,   1023, 1023, 3,    0, 1023, 3, 1, ST_INVALID, 0, 0, 0);
      add_row(ACT_ADD,     10,    0, 0, 1001, 1005, 3, 1, ST_ADDED,   0, 1, 1);
      add_row(ACT_ADD,     11,    0, 1, 1006, 1010, 3, 1, ST_ADDED,   3, 2, 1);
      // empty range, never matches
      add_row(ACT_ADD,     12,    0, 1, 1020, 1015, 1, 1, ST_ADDED,   1, 3, 1);
      add_row(ACT_ADD,     13,    0, 1, 1011, 1019, 2, 1, ST_ADDED,   2, 4, 1);
      add_row(ACT_ADD,     14,    0, 1, 1023, 1023, 0, 1, ST_ADDED,   0, 5, 1);
      add_row(ACT_ADMIT,   20, 1003, 0,    0,    0, 0, 0, ST_DROP,    0, 0, 0);
      add_row(ACT_ADMIT,   21, 1005, 0,    0,    0, 0, 0, ST_DROP,    0, 0, 0);
      add_row(ACT_ADMIT,   22, 1006, 0,    0,    0, 0, 0, ST_LOCAL,   0, 0, 0);
      add_row(ACT_ADMIT,   23, 1016, 0,    0,    0, 0, 0, ST_FORWARD, 0, 0, 0);
      add_row(ACT_ADMIT,   24, 1023, 0,    0,    0, 0, 0, ST_FORWARD, 0, 0, 0);
      add_row(ACT_ADMIT,   25, 1021, 0,    0,    0, 0, 0, ST_MISS,    0, 0, 0);
      add_row(ACT_ADMIT,   26,  250, 0,    0,    0, 0, 0, ST_LOCAL,   0, 0, 0);

      foreach (script[i]) send_item(script[i].req, script[i].typed, script[i].rsp);
      settle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               lo = '0;
               hi = IP_RESET_HIGH;
            end
            1: begin
               lo = '0;
               hi = '1;
            end
            2: begin
               lo = '1;
               hi = '0;
            end
            4: begin
               lo = IP_RESET_HIGH;
               hi = '1;
            end
            default: begin
               lo = IP_W'($urandom_range(0, 1023));
               hi = IP_W'($urandom_range(0, 1023));
            end
         endcase
         write_local_bounds(lo, hi);
         for (int n = 0; n < RANDOM_WORDS / NUM_PHASES; n++) send_item(pick_word(), 1'b0, none);
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
